@@ design/mm64a_pkg.sv @@
// ----------------------------------------------------------------------------
// mm64a_pkg
// Shared constants, types and helper functions of the MurmurHash64A stream
// hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package mm64a_pkg;

	localparam logic [63:0] MURMUR_M = 64'hc6a4a7935bd1e995;
	localparam logic [31:0] MURMUR_M_LO = MURMUR_M[31:0];
	localparam logic [31:0] MURMUR_M_HI = MURMUR_M[63:32];
	localparam int unsigned MIX_SHIFT = 47;
	localparam logic [3:0] FULL_BYTES = 4'd8;

	typedef struct packed {
		logic [63:0] k;
		logic [63:0] lenm;
		logic        first;
		logic        last;
		logic        fold;
	} work_t;

	function automatic logic [63:0] shx(input logic [63:0] x);
		return x ^ (x >> MIX_SHIFT);
	endfunction

	function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
		logic [63:0] m;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (i < int'(cnt)) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

@@ design/mm64a_if.sv @@
// ----------------------------------------------------------------------------
// mm64a interfaces
// Valid/ready channels for message words and finished hash values.
// ----------------------------------------------------------------------------
`default_nettype none

interface mm64a_msg_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic        first_word;
	logic        last_word;
	logic [31:0] message_length;

	modport source (output valid, data_word, valid_bytes, first_word, last_word,
		message_length, input ready);
	modport sink (input valid, data_word, valid_bytes, first_word, last_word,
		message_length, output ready);
endinterface

interface mm64a_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

`default_nettype wire

@@ design/mm64a_mul.sv @@
// ----------------------------------------------------------------------------
// mm64a_mul
// Two-stage multiply by the Murmur constant, modulo 2^64, from three
// 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module mm64a_mul (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] a,
	output logic [63:0]      p
);
	import mm64a_pkg::*;

	logic [63:0] pp0_s1;
	logic [31:0] pp1_s1;
	logic [31:0] pp2_s1;
	logic [63:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pp0_s1 <= {32'h0, a[31:0]} * {32'h0, MURMUR_M_LO};
			pp1_s1 <= a[31:0] * MURMUR_M_HI;
			pp2_s1 <= a[63:32] * MURMUR_M_LO;
			p_s2   <= pp0_s1 + {pp1_s1 + pp2_s1, 32'h0};
		end
	end

	assign p = p_s2;

endmodule

`default_nettype wire

@@ design/mm64a_front.sv @@
// ----------------------------------------------------------------------------
// mm64a_front
// Accept message words, classify them, mix full words and scale the length.
// ----------------------------------------------------------------------------
`default_nettype none

module mm64a_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	mm64a_msg_if.sink              msg,
	input  wire logic              q_full,
	output logic                   push,
	output mm64a_pkg::work_t       push_entry
);
	import mm64a_pkg::*;

	typedef struct packed {
		logic        full;
		logic        fold;
		logic        first;
		logic        last;
		logic [63:0] tail;
		logic [63:0] lenm;
	} side_t;

	logic        en;
	logic [3:0]  cnt;
	logic [63:0] k1;
	logic [63:0] lenm;
	logic [63:0] kmix;
	logic        v_s1, v_s2, v_s3, v_s4;
	side_t       side_s1, side_s2, side_s3, side_s4;

	assign en = !v_s4 || !q_full;
	assign msg.ready = en;
	assign cnt = (msg.valid_bytes > FULL_BYTES) ? FULL_BYTES : msg.valid_bytes;

	mm64a_mul u_mul_k1 (.clk(clk), .en(en), .a(msg.data_word), .p(k1));
	mm64a_mul u_mul_len (.clk(clk), .en(en), .a({32'h0, msg.message_length}), .p(lenm));
	mm64a_mul u_mul_k2 (.clk(clk), .en(en), .a(shx(k1)), .p(kmix));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= msg.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.full  <= (cnt == FULL_BYTES);
			side_s1.fold  <= (cnt != 4'd0);
			side_s1.first <= msg.first_word;
			side_s1.last  <= msg.last_word;
			side_s1.tail  <= msg.data_word & byte_mask(cnt);
			side_s1.lenm  <= '0;
			side_s2       <= side_s1;
			side_s3.full  <= side_s2.full;
			side_s3.fold  <= side_s2.fold;
			side_s3.first <= side_s2.first;
			side_s3.last  <= side_s2.last;
			side_s3.tail  <= side_s2.tail;
			side_s3.lenm  <= lenm;
			side_s4       <= side_s3;
		end
	end

	assign push = v_s4 && !q_full;

	always_comb begin
		push_entry.k     = side_s4.full ? kmix : side_s4.tail;
		push_entry.lenm  = side_s4.lenm;
		push_entry.first = side_s4.first;
		push_entry.last  = side_s4.last;
		push_entry.fold  = side_s4.fold;
	end

endmodule

`default_nettype wire

@@ design/mm64a_queue.sv @@
// ----------------------------------------------------------------------------
// mm64a_queue
// Two-entry queue of classified words between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mm64a_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  mm64a_pkg::work_t       push_entry,
	output logic                   full,
	input  wire logic              pop,
	output mm64a_pkg::work_t       head,
	output logic                   head_valid
);
	import mm64a_pkg::*;

	work_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

endmodule

`default_nettype wire

@@ design/mm64a_back.sv @@
// ----------------------------------------------------------------------------
// mm64a_back
// Fold queued words into the running hash, finalize and hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mm64a_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              seed_we,
	input  wire logic [63:0]       seed,
	input  mm64a_pkg::work_t       head,
	input  wire logic              head_valid,
	output logic                   pop,
	mm64a_hash_if.source           digest
);
	import mm64a_pkg::*;

	typedef enum logic [2:0] {IDLE, FOLD1, FOLD2, FIN1, FIN2} state_t;

	state_t      state_q;
	logic [63:0] seed_q;
	logic [63:0] h_q;
	logic        last_q;
	logic        out_valid_q;
	logic [63:0] out_q;
	logic [63:0] hb;
	logic [63:0] t;
	logic        out_free;
	logic [63:0] mul_a;
	logic [63:0] mul_p;

	assign hb       = head.first ? (seed_q ^ head.lenm) : h_q;
	assign t        = hb ^ head.k;
	assign out_free = !out_valid_q || digest.ready;
	assign pop      = (state_q == IDLE) && head_valid && (!head.last || out_free);
	assign mul_a    = (state_q == IDLE) ? (head.fold ? t : shx(t)) : shx(mul_p);

	mm64a_mul u_mul (.clk(clk), .en(1'b1), .a(mul_a), .p(mul_p));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			seed_q      <= '0;
			h_q         <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_we) begin
				seed_q <= seed;
			end
			if (out_valid_q && digest.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (pop) begin
						last_q <= head.last;
						if (head.fold) begin
							state_q <= FOLD1;
						end else begin
							h_q <= t;
							if (head.last) begin
								state_q <= FIN1;
							end
						end
					end
				end
				FOLD1: state_q <= FOLD2;
				FOLD2: begin
					h_q     <= mul_p;
					state_q <= last_q ? FIN1 : IDLE;
				end
				FIN1: state_q <= FIN2;
				FIN2: begin
					out_q       <= shx(mul_p);
					out_valid_q <= 1'b1;
					state_q     <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign digest.valid      = out_valid_q;
	assign digest.hash_value = out_q;

	a_out_free_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FIN2 |-> !out_valid_q || digest.ready)
		else $error("finished hash would overwrite a waiting result");

	a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == IDLE && head_valid)
		else $error("queue popped while busy");

	a_fin_follows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FIN1 |=> state_q == FIN2)
		else $error("finalize sequence broken");

endmodule

`default_nettype wire

@@ design/murmur64a_stream_hash.sv @@
// ----------------------------------------------------------------------------
// murmur64a_stream_hash
// MurmurHash64A over a message streamed as little-endian 64-bit words.
//
// msg carries one word per transaction with its valid byte count, first and
// last marks and the total message length (read on the first word only).
// digest carries one finalized hash per message, after its last word.
// hash_seed is loaded when hash_seed_we is high; write it while idle.
// The front accepts a word every cycle while msg.ready is high, into a
// four-stage mixing pipeline and a two-entry queue. The back folds each
// word into the running hash: a word with no valid bytes goes straight in
// from IDLE, any other word passes through states FOLD1 and FOLD2 while the
// two-stage multiplier in the hash recurrence works on it. A last word then
// passes through the finalization states FIN1 and FIN2.
// A result waits in the output register while digest.ready is low; the
// queue and front pipeline keep filling, then msg.ready drops.
// Reset clears the running hash, the seed, the queue and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur64a_stream_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        hash_seed_we,
	input  wire logic [63:0] hash_seed,
	mm64a_msg_if.sink        msg,
	mm64a_hash_if.source     digest
);
	import mm64a_pkg::*;

	logic  q_full;
	logic  push;
	work_t push_entry;
	logic  pop;
	work_t head;
	logic  head_valid;

	mm64a_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	mm64a_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	mm64a_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (hash_seed_we),
		.seed       (hash_seed),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.digest     (digest)
	);

endmodule

`default_nettype wire
